[hw/rtl/dia_pkg.sv]
// ----------------------------------------------------------------------------
// Descriptor number allocator package
// Shared constants, request and status codes, and controller types.
// ----------------------------------------------------------------------------
package dia_pkg;

	// Default size of the number pool; number 0 is never handed out.
	localparam int MaxIds = 64;

	// Fixed field widths on the stream ports.
	localparam int IdPortW = 6;
	localparam int KindW   = 2;
	localparam int StatusW = 2;

	// Request kinds carried in the input tuser.
	localparam logic [KindW-1:0] KindAlloc = 2'd0;
	localparam logic [KindW-1:0] KindFree  = 2'd1;
	localparam logic [KindW-1:0] KindQuery = 2'd2;

	// Result status codes.
	localparam logic [StatusW-1:0] StatusOk        = 2'd0;
	localparam logic [StatusW-1:0] StatusExhausted = 2'd1;
	localparam logic [StatusW-1:0] StatusInvalid   = 2'd2;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} dia_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic issue; // latch the request and start the memory reads
		logic exec;  // apply the update and load the result register
	} dia_cmd_t;

endpackage

[hw/rtl/dia_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module dia_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hw/rtl/dia_ctrl.sv]
// ----------------------------------------------------------------------------
// Descriptor number allocator controller
// Sequences each request through a read step and an update step and owns
// the valid flag of the result register.
// ----------------------------------------------------------------------------
module dia_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output dia_pkg::dia_cmd_t cmd
);

	dia_pkg::dia_state_t state_q;
	dia_pkg::dia_state_t state_d;
	logic                out_valid_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dia_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands. The update waits while an untaken result
	// still occupies the output register.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			dia_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.issue = 1'b1;
					state_d   = dia_pkg::ST_EXEC;
				end
			end
			dia_pkg::ST_EXEC: begin
				if (!out_valid_q || out_ready) begin
					cmd.exec = 1'b1;
					state_d  = dia_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dia_pkg::ST_IDLE;
			end
		endcase
	end

	// Result valid flag: set on load, cleared once the transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[hw/rtl/dia_dp.sv]
// ----------------------------------------------------------------------------
// Descriptor number allocator datapath
// Holds the high-water mark, the free stack and the in-use bits, and computes
// each request's update and result.
// ----------------------------------------------------------------------------
module dia_dp #(
	parameter int MAX_IDS = dia_pkg::MaxIds
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dia_pkg::dia_cmd_t            cmd,
	input  logic [dia_pkg::KindW-1:0]    in_kind,
	input  logic [dia_pkg::IdPortW-1:0]  in_target_id,
	output logic [dia_pkg::IdPortW-1:0]  result_id,
	output logic [dia_pkg::StatusW-1:0]  status,
	output logic                         is_live
);

	localparam int IdW  = $clog2(MAX_IDS);
	localparam int CntW = $clog2(MAX_IDS + 1);
	localparam int CmpW = (CntW > dia_pkg::IdPortW) ? CntW : dia_pkg::IdPortW;

	logic [dia_pkg::KindW-1:0]   kind_q;
	logic [dia_pkg::IdPortW-1:0] target_q;
	logic [CntW-1:0]             high_water_q;
	logic [CntW-1:0]             free_count_q;
	logic [dia_pkg::IdPortW-1:0] result_id_q;
	logic [dia_pkg::StatusW-1:0] status_q;
	logic                        is_live_q;

	logic                        inuse_rd;
	logic                        inuse_we;
	logic [IdW-1:0]              inuse_waddr;
	logic                        inuse_wdata;
	logic [IdW-1:0]              stack_rd;
	logic                        stack_we;
	logic [IdW-1:0]              stack_rd_addr;

	logic [CmpW-1:0]             tgt_ext;
	logic [CmpW-1:0]             hw_ext;
	logic                        tgt_live;
	logic                        tgt_top;
	logic [CntW-1:0]             high_water_d;
	logic [CntW-1:0]             free_count_d;
	logic [dia_pkg::IdPortW-1:0] result_id_d;
	logic [dia_pkg::StatusW-1:0] status_d;
	logic                        is_live_d;

	// Request capture at the input transfer.
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			kind_q   <= in_kind;
			target_q <= in_target_id;
		end
	end

	// Entries at or above the high-water mark are never read as live, and
	// every nonzero number below it was written when it was handed out, so the
	// in-use memory needs no clearing.
	dia_ram #(
		.Width (1),
		.Depth (MAX_IDS)
	) u_inuse_ram (
		.clk     (clk),
		.wr_en   (inuse_we),
		.wr_addr (inuse_waddr),
		.wr_data (inuse_wdata),
		.rd_en   (cmd.issue),
		.rd_addr (IdW'(in_target_id)),
		.rd_data (inuse_rd)
	);

	// The free stack is read at its top while the request is captured.
	assign stack_rd_addr = IdW'(free_count_q - CntW'(1));

	dia_ram #(
		.Width (IdW),
		.Depth (MAX_IDS)
	) u_stack_ram (
		.clk     (clk),
		.wr_en   (stack_we),
		.wr_addr (IdW'(free_count_q)),
		.wr_data (IdW'(target_q)),
		.rd_en   (cmd.issue),
		.rd_addr (stack_rd_addr),
		.rd_data (stack_rd)
	);

	// Liveness of the captured number.
	assign tgt_ext  = CmpW'(target_q);
	assign hw_ext   = CmpW'(high_water_q);
	assign tgt_live = (target_q != '0) && (tgt_ext < hw_ext) && inuse_rd;
	assign tgt_top  = (tgt_ext == (hw_ext - CmpW'(1)));

	// Update and result for the captured request.
	always_comb begin
		high_water_d = high_water_q;
		free_count_d = free_count_q;
		result_id_d  = '0;
		status_d     = dia_pkg::StatusOk;
		is_live_d    = 1'b0;
		inuse_we     = 1'b0;
		inuse_waddr  = IdW'(target_q);
		inuse_wdata  = 1'b0;
		stack_we     = 1'b0;
		case (kind_q)
			dia_pkg::KindAlloc: begin
				if (free_count_q != '0) begin
					// Reuse the most recently freed number.
					free_count_d = free_count_q - CntW'(1);
					inuse_we     = 1'b1;
					inuse_waddr  = stack_rd;
					inuse_wdata  = 1'b1;
					result_id_d  = dia_pkg::IdPortW'(stack_rd);
				end else if (high_water_q < CntW'(MAX_IDS)) begin
					// Take the number at the high-water mark.
					high_water_d = high_water_q + CntW'(1);
					inuse_we     = 1'b1;
					inuse_waddr  = IdW'(high_water_q);
					inuse_wdata  = 1'b1;
					result_id_d  = dia_pkg::IdPortW'(high_water_q);
				end else begin
					status_d = dia_pkg::StatusExhausted;
				end
			end
			dia_pkg::KindFree: begin
				if (tgt_live) begin
					inuse_we    = 1'b1;
					result_id_d = target_q;
					if (tgt_top) begin
						high_water_d = high_water_q - CntW'(1);
					end else if (free_count_q < CntW'(MAX_IDS)) begin
						stack_we     = 1'b1;
						free_count_d = free_count_q + CntW'(1);
					end
				end else begin
					status_d = dia_pkg::StatusInvalid;
				end
			end
			dia_pkg::KindQuery: begin
				result_id_d = target_q;
				is_live_d   = tgt_live;
			end
			default: begin
				status_d = dia_pkg::StatusInvalid;
			end
		endcase
		if (!cmd.exec) begin
			inuse_we = 1'b0;
			stack_we = 1'b0;
		end
	end

	// Pool bookkeeping registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_water_q <= CntW'(1);
			free_count_q <= '0;
		end else if (cmd.exec) begin
			high_water_q <= high_water_d;
			free_count_q <= free_count_d;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			result_id_q <= result_id_d;
			status_q    <= status_d;
			is_live_q   <= is_live_d;
		end
	end

	assign result_id = result_id_q;
	assign status    = status_q;
	assign is_live   = is_live_q;

endmodule

[hw/rtl/descriptor_id_allocator_core.sv]
// ----------------------------------------------------------------------------
// Descriptor number allocator
// Allocates, frees and checks small descriptor numbers from a pool.
// ----------------------------------------------------------------------------
// Each request transfer produces exactly one result transfer. A request passes
// through the registered read of the in-use and free-stack memories and then
// the update, which applies it and loads the result register. A new request
// is taken while an earlier result still waits in the output register; only
// a result that has not been taken by the time the next update is ready holds
// the block. No clearing pass follows reset: the high-water mark bounds which
// in-use entries can be read.
module descriptor_id_allocator_core #(
	parameter int MAX_IDS = dia_pkg::MaxIds
) (
	input  logic        clk,
	input  logic        arst_n,
	// Requests
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [5:0] target_id, [7:6] zero
	input  logic [1:0]  s_tuser,  // [1:0] kind
	// Results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // [5:0] result_id, [7:6] status, [8] is_live, [15:9] zero
);

	dia_pkg::dia_cmd_t            cmd;
	logic [dia_pkg::IdPortW-1:0]  result_id;
	logic [dia_pkg::StatusW-1:0]  status;
	logic                         is_live;

	// Sequencing and handshakes.
	dia_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	// Pool state and result computation.
	dia_dp #(
		.MAX_IDS (MAX_IDS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.in_kind      (s_tuser),
		.in_target_id (s_tdata[5:0]),
		.result_id    (result_id),
		.status       (status),
		.is_live      (is_live)
	);

	assign m_tdata = {7'd0, is_live, status, result_id};

endmodule

[bench/tb_descriptor_id_allocator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descriptor number allocator testbench
// Drives allocate, free, query and unused-kind requests into the allocator and
// checks every result transfer against a cycle-free model of the pool, or a typed
// row's given result, first from a table of directed cases and then from random
// traffic that swings the pool between empty and exhausted under varying back-pressure.
// ----------------------------------------------------------------------------
module tb_descriptor_id_allocator_core;

	// The request kind that the block leaves unused.
	localparam logic [dia_pkg::KindW-1:0] KindUnused = 2'd3;

	localparam int ItemsPerPhase = 300;
	localparam int QuietLimit    = 2000;
	localparam int DrainCycles   = 20;

	// One result transfer, packed as it appears in m_tdata[8:0].
	typedef struct packed {
		logic                        is_live;
		logic [dia_pkg::StatusW-1:0] status;
		logic [dia_pkg::IdPortW-1:0] result_id;
	} alloc_result_t;

	// One row of the directed table; count repeats the request.
	typedef struct packed {
		logic [dia_pkg::KindW-1:0]   kind;
		logic [dia_pkg::IdPortW-1:0] id;
		logic [7:0]                  count;
		logic                        typed;
		alloc_result_t               given;
	} dir_row_t;

	localparam int DirRowCount = 26;
	localparam dir_row_t DirRows [DirRowCount] = '{
		// Empty pool: out-of-range queries and frees, unused kind.
		'{dia_pkg::KindQuery, 6'd0,  8'd1,  1'b1, '{1'b0, dia_pkg::StatusOk,        6'd0}},
		'{dia_pkg::KindQuery, 6'd63, 8'd1,  1'b1, '{1'b0, dia_pkg::StatusOk,        6'd63}},
		'{dia_pkg::KindFree,  6'd0,  8'd1,  1'b1, '{1'b0, dia_pkg::StatusInvalid,   6'd0}},
		'{dia_pkg::KindFree,  6'd63, 8'd1,  1'b1, '{1'b0, dia_pkg::StatusInvalid,   6'd0}},
		'{KindUnused,         6'd42, 8'd1,  1'b1, '{1'b0, dia_pkg::StatusInvalid,   6'd0}},
		// First numbers come from the high-water mark.
		'{dia_pkg::KindAlloc, 6'd63, 8'd1,  1'b1, '{1'b0, dia_pkg::StatusOk,        6'd1}},
		'{dia_pkg::KindAlloc, 6'd0,  8'd1,  1'b1, '{1'b0, dia_pkg::StatusOk,        6'd2}},
		'{dia_pkg::KindAlloc, 6'd21, 8'd1,  1'b1, '{1'b0, dia_pkg::StatusOk,        6'd3}},
		'{dia_pkg::KindQuery, 6'd2,  8'd1,  1'b1, '{1'b1, dia_pkg::StatusOk,        6'd2}},
		// A middle number goes on the stack; a second free is refused.
		'{dia_pkg::KindFree,  6'd2,  8'd1,  1'b1, '{1'b0, dia_pkg::StatusOk,        6'd2}},
		'{dia_pkg::KindFree,  6'd2,  8'd1,  1'b1, '{1'b0, dia_pkg::StatusInvalid,   6'd0}},
		'{dia_pkg::KindQuery, 6'd2,  8'd1,  1'b1, '{1'b0, dia_pkg::StatusOk,        6'd2}},
		'{dia_pkg::KindAlloc, 6'd0,  8'd1,  1'b1, '{1'b0, dia_pkg::StatusOk,        6'd2}},
		// The topmost number lowers the mark instead.
		'{dia_pkg::KindFree,  6'd3,  8'd1,  1'b1, '{1'b0, dia_pkg::StatusOk,        6'd3}},
		'{dia_pkg::KindQuery, 6'd3,  8'd1,  1'b1, '{1'b0, dia_pkg::StatusOk,        6'd3}},
		'{dia_pkg::KindAlloc, 6'd0,  8'd1,  1'b1, '{1'b0, dia_pkg::StatusOk,        6'd3}},
		// Fill the pool, then run into exhaustion.
		'{dia_pkg::KindAlloc, 6'd63, 8'd60, 1'b0, '{1'b0, dia_pkg::StatusOk,        6'd0}},
		'{dia_pkg::KindAlloc, 6'd0,  8'd1,  1'b1, '{1'b0, dia_pkg::StatusExhausted, 6'd0}},
		'{dia_pkg::KindQuery, 6'd63, 8'd1,  1'b1, '{1'b1, dia_pkg::StatusOk,        6'd63}},
		'{dia_pkg::KindFree,  6'd63, 8'd1,  1'b1, '{1'b0, dia_pkg::StatusOk,        6'd63}},
		'{dia_pkg::KindFree,  6'd10, 8'd1,  1'b0, '{1'b0, dia_pkg::StatusOk,        6'd0}},
		'{dia_pkg::KindFree,  6'd20, 8'd1,  1'b0, '{1'b0, dia_pkg::StatusOk,        6'd0}},
		'{dia_pkg::KindAlloc, 6'd0,  8'd1,  1'b0, '{1'b0, dia_pkg::StatusOk,        6'd0}},
		'{dia_pkg::KindAlloc, 6'd0,  8'd1,  1'b0, '{1'b0, dia_pkg::StatusOk,        6'd0}},
		'{dia_pkg::KindAlloc, 6'd0,  8'd1,  1'b0, '{1'b0, dia_pkg::StatusOk,        6'd0}},
		'{dia_pkg::KindAlloc, 6'd0,  8'd1,  1'b1, '{1'b0, dia_pkg::StatusExhausted, 6'd0}}
	};

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;  // [5:0] target_id, [7:6] zero
	logic [1:0]  s_tuser  = '0;  // [1:0] kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [5:0] result_id, [7:6] status, [8] is_live, [15:9] zero

	// Model of the pool: in-use map, high-water mark and free stack.
	logic [dia_pkg::MaxIds-1:0]  live_map = '0;
	logic [6:0]                  hw_mark  = 7'd1;
	logic [dia_pkg::IdPortW-1:0] freed_ids [$];

	alloc_result_t expected_results [$];
	int            mismatches     = 0;
	int            send_idle_pct  = 25;
	int            recv_stall_pct = 64;
	int            quiet_cycles   = 0;

	descriptor_id_allocator_core #(
		.MAX_IDS(dia_pkg::MaxIds)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Applies one request to the pool model and returns its result.
	function automatic alloc_result_t predict_request(logic [dia_pkg::KindW-1:0] kind,
			logic [dia_pkg::IdPortW-1:0] id);
		alloc_result_t r;
		logic          live;
		r    = '0;
		live = (id != 0) && (id < hw_mark) && live_map[id];
		case (kind)
			dia_pkg::KindAlloc: begin
				if (freed_ids.size() > 0) begin
					r.result_id = freed_ids.pop_back();
					live_map[r.result_id] = 1'b1;
				end else if (hw_mark < dia_pkg::MaxIds) begin
					r.result_id = hw_mark[dia_pkg::IdPortW-1:0];
					live_map[hw_mark[dia_pkg::IdPortW-1:0]] = 1'b1;
					hw_mark = hw_mark + 7'd1;
				end else begin
					r.status = dia_pkg::StatusExhausted;
				end
			end
			dia_pkg::KindFree: begin
				if (live) begin
					live_map[id] = 1'b0;
					if (id == hw_mark - 7'd1)
						hw_mark = hw_mark - 7'd1;
					else if (freed_ids.size() < dia_pkg::MaxIds)
						freed_ids.push_back(id);
					r.result_id = id;
				end else begin
					r.status = dia_pkg::StatusInvalid;
				end
			end
			dia_pkg::KindQuery: begin
				r.result_id = id;
				r.is_live   = live;
			end
			default: begin
				r.status = dia_pkg::StatusInvalid;
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int exp_val, input int got_val);
		$display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, exp_val, got_val);
		mismatches++;
	endtask

	// Offers one request, with random idle cycles first, and records the
	// expected result once the transfer has taken place. Called at a rising edge.
	task automatic send_request(input logic [dia_pkg::KindW-1:0] kind,
			input logic [dia_pkg::IdPortW-1:0] id,
			input logic typed, input alloc_result_t given);
		alloc_result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {2'b00, id};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = predict_request(kind, id);
		expected_results.push_back(typed ? given : predicted);
	endtask

	// Result side: check each transfer and stall at random.
	always @(posedge clk) begin
		alloc_result_t exp_res;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result_id", -1, int'(m_tdata[5:0]));
				end else begin
					exp_res = expected_results.pop_front();
					if (m_tdata[5:0] !== exp_res.result_id)
						report_mismatch("result_id", int'(exp_res.result_id),
							int'(m_tdata[5:0]));
					if (m_tdata[7:6] !== exp_res.status)
						report_mismatch("status", int'(exp_res.status), int'(m_tdata[7:6]));
					if (m_tdata[8] !== exp_res.is_live)
						report_mismatch("is_live", int'(exp_res.is_live), int'(m_tdata[8]));
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: ends the run after a long stretch without any transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QuietLimit) begin
				$display("[%0t] no transfer for %0d cycles", $time, QuietLimit);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Stimulus: the directed table, then random traffic in three phases of sender idling and receiver stalls.
	initial begin
		alloc_result_t               no_given;
		logic [dia_pkg::KindW-1:0]   kind;
		logic [dia_pkg::IdPortW-1:0] id;
		logic [dia_pkg::IdPortW-1:0] live_ids [$];
		int                          roll;
		bit                          filling;
		no_given = '0;
		filling  = 1'b0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DirRowCount; r++)
			repeat (DirRows[r].count)
				send_request(DirRows[r].kind, DirRows[r].id, DirRows[r].typed,
					DirRows[r].given);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct  = (phase == 0) ? 25 : (phase == 1) ? 64 : 0;
			recv_stall_pct = (phase == 0) ? 64 : (phase == 1) ? 25 : 0;
			for (int item = 0; item < ItemsPerPhase; item++) begin
				live_ids.delete();
				for (int n = 1; n < dia_pkg::MaxIds; n++)
					if (live_map[n])
						live_ids.push_back(6'(n));

				// Swing the pool between empty and exhausted.
				if (filling && freed_ids.size() == 0 && hw_mark == dia_pkg::MaxIds)
					filling = 1'b0;
				else if (!filling && live_ids.size() == 0)
					filling = 1'b1;
				else if ($urandom_range(99) == 0)
					filling = !filling;

				roll = $urandom_range(99);
				id   = 6'($urandom_range(63));
				if (roll < 10) begin
					// Noise: any kind with any number.
					kind = 2'($urandom_range(3));
				end else if (roll < 25) begin
					kind = dia_pkg::KindQuery;
					if (live_ids.size() > 0 && $urandom_range(1))
						id = live_ids[$urandom_range(live_ids.size() - 1)];
				end else if (live_ids.size() == 0
						|| $urandom_range(99) < (filling ? 75 : 25)) begin
					kind = dia_pkg::KindAlloc;
				end else begin
					kind = dia_pkg::KindFree;
					if ($urandom_range(9) != 0)
						id = live_ids[$urandom_range(live_ids.size() - 1)];
				end
				send_request(kind, id, 1'b0, no_given);
			end
		end
		s_tvalid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
